FILE: src/ip_address_text_validator_core_assert.svh
// ----------------------------------------------------------------------------
// IP address text validator assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_CORE_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IPATV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipatv assertion failed");
`define IPATV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ipatv assertion failed");
`else
`define IPATV_ASSERT(lbl, clk, rst, prop)
`define IPATV_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/ipatv_pkg.sv
// ----------------------------------------------------------------------------
// IP address text validator package
// Character codes, limits, register indexes and the parser step controls.
// ----------------------------------------------------------------------------
package ipatv_pkg;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [2:0] V4_LAST_PART  = 3'd3;
  localparam logic [2:0] V4_PARTS      = 3'd4;
  localparam logic [1:0] V4_MAX_DIGITS = 2'd3;
  localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
  localparam logic [3:0] V6_LAST_PART  = 4'd7;
  localparam logic [3:0] V6_PARTS      = 4'd8;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_V4 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_V6 = 2'd1;

  typedef struct packed {
    logic       take;
    logic       clear;
    logic [7:0] ch;
  } ipatv_step_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

FILE: src/ipatv_if.sv
// ----------------------------------------------------------------------------
// IP address text validator channels
// Character request, verdict result and register write channels.
// ----------------------------------------------------------------------------
interface ipatv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       ch_present;
  logic       last;
  modport source (output valid, ch, ch_present, last, input ready);
  modport sink (input valid, ch, ch_present, last, output ready);
endinterface

interface ipatv_out_if;
  logic valid;
  logic ready;
  logic ip_valid;
  logic v6_form;
  modport source (output valid, ip_valid, v6_form, input ready);
  modport sink (input valid, ip_valid, v6_form, output ready);
endinterface

interface ipatv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/ipatv_v4_parser.sv
// ----------------------------------------------------------------------------
// IPv4 dotted-decimal parser
// Tracks parts, digits and part value; reports the end-of-string verdict.
// ----------------------------------------------------------------------------
module ipatv_v4_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  ipatv_pkg::ipatv_step_t step,
  output logic                  ok
);
  import ipatv_pkg::*;

  logic [2:0] parts, parts_next;
  logic [1:0] digits, digits_next;
  logic [9:0] value, value_next;
  logic       failed, failed_next;
  logic       prev_dot, prev_dot_next;

  always_comb begin
    parts_next    = parts;
    digits_next   = digits;
    value_next    = value;
    failed_next   = failed;
    prev_dot_next = prev_dot;
    if (step.take) begin
      prev_dot_next = (step.ch == CHAR_DOT);
      if (!failed) begin
        if (step.ch == CHAR_DOT) begin
          if ((digits == 2'd0) || (value > V4_MAX_VALUE)) begin
            failed_next = 1'b1;
          end else begin
            parts_next = parts + 3'd1;
            if (parts_next >= V4_PARTS) begin
              failed_next = 1'b1;
            end else begin
              digits_next = 2'd0;
              value_next  = 10'd0;
            end
          end
        end else if (is_dec(step.ch)) begin
          if (digits >= V4_MAX_DIGITS) begin
            failed_next = 1'b1;
          end else begin
            value_next  = 10'(value * 10'd10) + {6'd0, step.ch[3:0]};
            digits_next = digits + 2'd1;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  assign ok = !failed_next && !prev_dot_next && (digits_next != 2'd0) &&
              (value_next <= V4_MAX_VALUE) && (parts_next == V4_LAST_PART);

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      parts    <= '0;
      digits   <= '0;
      value    <= '0;
      failed   <= 1'b0;
      prev_dot <= 1'b0;
    end else if (step.take) begin
      parts    <= parts_next;
      digits   <= digits_next;
      value    <= value_next;
      failed   <= failed_next;
      prev_dot <= prev_dot_next;
    end
  end

endmodule

FILE: src/ipatv_v6_parser.sv
// ----------------------------------------------------------------------------
// IPv6 colon-hex parser
// Tracks parts, digits and the shorthand; reports the end-of-string verdict.
// ----------------------------------------------------------------------------
module ipatv_v6_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  ipatv_pkg::ipatv_step_t step,
  output logic                  ok
);
  import ipatv_pkg::*;

  logic [3:0] parts, parts_next;
  logic [2:0] digits, digits_next;
  logic       shorthand, shorthand_next;
  logic       failed, failed_next;
  logic       prev_colon, prev_colon_next;
  logic       at_start, at_start_next;

  always_comb begin
    parts_next      = parts;
    digits_next     = digits;
    shorthand_next  = shorthand;
    failed_next     = failed;
    prev_colon_next = prev_colon;
    at_start_next   = at_start;
    if (step.take) begin
      prev_colon_next = (step.ch == CHAR_COLON);
      at_start_next   = 1'b0;
      if (!failed) begin
        if (step.ch == CHAR_COLON) begin
          if (!at_start && prev_colon && shorthand) begin
            failed_next = 1'b1;
          end else begin
            if (!at_start && prev_colon) begin
              shorthand_next = 1'b1;
            end
            parts_next = parts + 4'd1;
            if (parts_next >= V6_PARTS) begin
              failed_next = 1'b1;
            end else begin
              digits_next = 3'd0;
            end
          end
        end else if (is_hex(step.ch)) begin
          if (digits >= V6_MAX_DIGITS) begin
            failed_next = 1'b1;
          end else begin
            digits_next = digits + 3'd1;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  assign ok = !failed_next && !(!at_start_next && prev_colon_next) &&
              (shorthand_next ? (parts_next <= V6_LAST_PART) : (parts_next == V6_LAST_PART));

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      parts      <= '0;
      digits     <= '0;
      shorthand  <= 1'b0;
      failed     <= 1'b0;
      prev_colon <= 1'b0;
      at_start   <= 1'b1;
    end else if (step.take) begin
      parts      <= parts_next;
      digits     <= digits_next;
      shorthand  <= shorthand_next;
      failed     <= failed_next;
      prev_colon <= prev_colon_next;
      at_start   <= at_start_next;
    end
  end

endmodule

FILE: src/ip_address_text_validator_core.sv
// ----------------------------------------------------------------------------
// IP address text validator core
// Checks IPv4 dotted-decimal or IPv6 colon-hex text, one character a request.
//
// chars takes one request per character: ch, ch_present and last. A request
// with ch_present low and last low is dropped; last gives one verdict on
// verdict (ip_valid, v6_form) and clears the parse state. Both parsers see
// every character; a colon anywhere selects the IPv6 verdict.
// cfg writes allow_v4 (index 0) and allow_v6 (index 1); it is always ready
// and other indexes are ignored. Write it only while idle.
// A request enters the input register when it is accepted; a last request's
// verdict is registered as that request leaves the input register.
// Throughput: one request per cycle, set by the single input register and
// the single verdict register. A verdict stalled on verdict.ready holds the
// input register only when it also carries last; other characters flow on.
// Reset: synchronous; parse state cleared, both forms allowed, no verdict.
// ----------------------------------------------------------------------------
`include "ip_address_text_validator_core_assert.svh"

module ip_address_text_validator_core (
  input logic        clk,
  input logic        rst,
  ipatv_in_if.sink   chars,
  ipatv_out_if.source verdict,
  ipatv_cfg_if.sink  cfg
);
  import ipatv_pkg::*;

  logic        allow_v4;
  logic        allow_v6;
  logic        s1_valid;
  logic [7:0]  s1_ch;
  logic        s1_present;
  logic        s1_last;
  logic        s1_adv;
  logic        colon_seen, colon_seen_next;
  logic        o_valid;
  logic        o_ip_valid;
  logic        o_v6_form;
  logic        v4_ok;
  logic        v6_ok;
  ipatv_step_t step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_v4 <= 1'b1;
      allow_v6 <= 1'b1;
    end else if (cfg.valid) begin
      if (cfg.index == REG_ALLOW_V4) begin
        allow_v4 <= cfg.data;
      end else if (cfg.index == REG_ALLOW_V6) begin
        allow_v6 <= cfg.data;
      end
    end
  end

  assign s1_adv      = s1_valid && (!s1_last || !o_valid || verdict.ready);
  assign chars.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_ch      <= chars.ch;
      s1_present <= chars.ch_present;
      s1_last    <= chars.last;
    end
  end

  assign step.take  = s1_adv && s1_present;
  assign step.clear = s1_adv && s1_last;
  assign step.ch    = s1_ch;

  ipatv_v4_parser u_v4 (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ok   (v4_ok)
  );

  ipatv_v6_parser u_v6 (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ok   (v6_ok)
  );

  assign colon_seen_next = colon_seen || (step.take && (s1_ch == CHAR_COLON));

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      colon_seen <= 1'b0;
    end else begin
      colon_seen <= colon_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (step.clear) begin
      o_valid <= 1'b1;
    end else if (verdict.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.clear) begin
      o_v6_form  <= colon_seen_next;
      o_ip_valid <= colon_seen_next ? (allow_v6 && v6_ok) : (allow_v4 && v4_ok);
    end
  end

  assign verdict.valid    = o_valid;
  assign verdict.ip_valid = o_ip_valid;
  assign verdict.v6_form  = o_v6_form;

  `IPATV_ASSERT_ALWAYS(a_no_verdict_after_reset, clk, $past(rst) |-> !o_valid)
  `IPATV_ASSERT(a_verdict_from_last, clk, rst, $rose(o_valid) |-> $past(step.clear))
  `IPATV_ASSERT(a_form_follows_colon, clk, rst, step.clear |=> (o_v6_form == $past(colon_seen_next)))
  `IPATV_ASSERT(a_held_stage_blocks, clk, rst, (s1_valid && !s1_adv) |-> !chars.ready)

endmodule
